>>> design/masr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masr_pkg
// Shared sizes, codes and types for the masked SAD nearest-row search.
// ----------------------------------------------------------------------------
package masr_pkg;

   localparam int ROWS      = 8192;
   localparam int ANGLES    = 72;
   localparam int DIST_BITS = 16;

   localparam int ROW_BITS        = 13;
   localparam int ANGLE_BITS      = 7;
   localparam int COUNT_BITS      = 14;
   localparam int SUM_BITS        = 24;
   localparam int KIND_BITS       = 2;
   localparam int CSR_ADDR_BITS   = 2;
   localparam int CSR_DATA_BITS   = 24;
   localparam int TABLE_DEPTH     = ROWS * ANGLES;
   localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int QUERY_ADDR_BITS = $clog2(ANGLES);

   localparam logic [SUM_BITS-1:0] SUM_MAX         = {SUM_BITS{1'b1}};
   localparam logic [SUM_BITS-1:0] ERROR_LIMIT_RST = SUM_BITS'(12800000);

   // Request kinds
   localparam logic [KIND_BITS-1:0] KIND_TABLE_WRITE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_QUERY_WRITE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SEARCH      = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FIRST_ANGLE = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_END_ANGLE   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROW_COUNT   = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ERROR_LIMIT = 2'd3;

   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [ROW_BITS-1:0] row;
      logic                present;
   } masr_tag_type;

   typedef struct packed {
      logic         start;
      logic         empty_win;
      logic         no_rows;
      masr_tag_type tag;
   } masr_ctl_type;

   typedef struct packed {
      logic                found;
      logic [SUM_BITS-1:0] best_error;
      logic [ROW_BITS-1:0] best_row;
   } masr_result_type;

endpackage
`default_nettype wire

>>> design/masr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masr_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module masr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 72
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> design/masr_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masr_acc
// Difference, saturating row accumulation and running minimum.
// ----------------------------------------------------------------------------
module masr_acc import masr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire masr_ctl_type         ctl,
   input  wire logic [DIST_BITS-1:0] table_rdata,
   input  wire logic [DIST_BITS-1:0] query_rdata,
   input  wire logic [SUM_BITS-1:0]  error_limit,
   output logic                      busy,
   output masr_result_type           result
);

   masr_tag_type         s1_ff, s1_in;
   logic                 s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [ROW_BITS-1:0]  s2_row_ff;
   logic [DIST_BITS-1:0] diff_ff, diff_in;
   logic                 s3_valid_ff, s3_last_ff;
   logic [ROW_BITS-1:0]  s3_row_ff;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [SUM_BITS-1:0]  best_err_ff, best_err_in;
   logic [ROW_BITS-1:0]  best_row_ff, best_row_in;
   logic                 hit_ff, hit_in;
   logic [SUM_BITS:0]    sum_wide;
   logic [SUM_BITS-1:0]  sum_base;

   always_comb begin
      s1_in = ctl.tag;

      // Absent query entries contribute nothing.
      if (!s1_ff.present) begin
         diff_in = '0;
      end else if (query_rdata >= table_rdata) begin
         diff_in = query_rdata - table_rdata;
      end else begin
         diff_in = table_rdata - query_rdata;
      end

      sum_base = s2_first_ff ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base} + (SUM_BITS+1)'(diff_ff);
      sum_in   = sum_ff;
      if (s2_valid_ff) begin
         sum_in = (sum_wide >= {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_BITS-1:0];
      end

      best_err_in = best_err_ff;
      best_row_in = best_row_ff;
      hit_in      = hit_ff;
      if (ctl.start) begin
         best_err_in = error_limit;
         best_row_in = '0;
         hit_in      = 1'b0;
         // With an empty window every row sums to zero, so row 0 wins.
         if (!ctl.no_rows && ctl.empty_win && error_limit != '0) begin
            best_err_in = '0;
            hit_in      = 1'b1;
         end
      end else if (s3_valid_ff && s3_last_ff && sum_ff < best_err_ff) begin
         best_err_in = sum_ff;
         best_row_in = s3_row_ff;
         hit_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         s1_ff       <= s1_in;
         s2_valid_ff <= s1_ff.valid;
         s3_valid_ff <= s2_valid_ff;
         hit_ff      <= hit_in;
      end
      s2_first_ff <= s1_ff.first;
      s2_last_ff  <= s1_ff.last;
      s2_row_ff   <= s1_ff.row;
      diff_ff     <= diff_in;
      s3_last_ff  <= s2_last_ff;
      s3_row_ff   <= s2_row_ff;
      sum_ff      <= sum_in;
      best_err_ff <= best_err_in;
      best_row_ff <= best_row_in;
   end

   assign busy              = s1_ff.valid | s2_valid_ff | s3_valid_ff;
   assign result.found      = hit_ff;
   assign result.best_error = best_err_ff;
   assign result.best_row   = best_row_ff;

endmodule
`default_nettype wire

>>> design/masr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masr_seq
// Request handling, memory addressing and search sequencing.
// ----------------------------------------------------------------------------
module masr_seq import masr_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [KIND_BITS-1:0]       req_kind,
   input  wire logic [ROW_BITS-1:0]        req_row,
   input  wire logic [ANGLE_BITS-1:0]      req_angle,
   input  wire logic                       req_present,
   input  wire logic [ANGLE_BITS-1:0]      first_angle,
   input  wire logic [ANGLE_BITS-1:0]      end_angle,
   input  wire logic [COUNT_BITS-1:0]      row_count,
   input  wire logic                       acc_busy,
   input  wire masr_result_type            acc_result,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output masr_result_type                 rsp_data,
   output logic                            table_we,
   output logic [TABLE_ADDR_BITS-1:0]      table_addr,
   output logic                            query_we,
   output logic [QUERY_ADDR_BITS-1:0]      query_addr,
   output masr_ctl_type                    ctl
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_type;

   state_type                  state_ff, state_in;
   logic [ANGLES-1:0]          present_ff, present_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;
   logic [ROW_BITS-1:0]        last_row_ff, last_row_in;
   logic [ANGLE_BITS-1:0]      angle_ff, angle_in;
   logic [ANGLE_BITS-1:0]      lo_ff, lo_in;
   logic [ANGLE_BITS-1:0]      hi_ff, hi_in;
   logic [TABLE_ADDR_BITS-1:0] base_ff, base_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   masr_result_type            rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  angle_ok;
   logic                  run;
   logic                  row_end;
   logic [ANGLE_BITS-1:0] hi_w;
   logic [COUNT_BITS-1:0] rows_w;
   logic                  empty_win;
   logic                  no_rows;

   always_comb begin
      accept    = req_valid && (state_ff == ST_IDLE);
      angle_ok  = req_angle < ANGLE_BITS'(ANGLES);
      run       = (state_ff == ST_RUN);
      row_end   = (angle_ff + ANGLE_BITS'(1)) == hi_ff;
      hi_w      = (end_angle < ANGLE_BITS'(ANGLES)) ? end_angle : ANGLE_BITS'(ANGLES);
      rows_w    = (row_count > COUNT_BITS'(ROWS)) ? COUNT_BITS'(ROWS) : row_count;
      empty_win = first_angle >= hi_w;
      no_rows   = (row_count == '0);

      table_we   = accept && (req_kind == KIND_TABLE_WRITE) && angle_ok;
      query_we   = accept && (req_kind == KIND_QUERY_WRITE) && angle_ok;
      table_addr = run ? (base_ff + TABLE_ADDR_BITS'(angle_ff))
                       : (TABLE_ADDR_BITS'(req_row) * TABLE_ADDR_BITS'(ANGLES)
                          + TABLE_ADDR_BITS'(req_angle));
      query_addr = run ? angle_ff[QUERY_ADDR_BITS-1:0] : req_angle[QUERY_ADDR_BITS-1:0];

      ctl.start       = accept && (req_kind == KIND_SEARCH);
      ctl.empty_win   = empty_win;
      ctl.no_rows     = no_rows;
      ctl.tag.valid   = run;
      ctl.tag.first   = (angle_ff == lo_ff);
      ctl.tag.last    = row_end;
      ctl.tag.row     = row_ff;
      ctl.tag.present = present_ff[angle_ff[QUERY_ADDR_BITS-1:0]];

      state_in     = state_ff;
      present_in   = present_ff;
      row_in       = row_ff;
      last_row_in  = last_row_ff;
      angle_in     = angle_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (query_we) begin
               present_in[req_angle[QUERY_ADDR_BITS-1:0]] = req_present;
            end
            if (ctl.start) begin
               lo_in       = first_angle;
               hi_in       = hi_w;
               angle_in    = first_angle;
               row_in      = '0;
               base_in     = '0;
               last_row_in = ROW_BITS'(rows_w - COUNT_BITS'(1));
               state_in    = (no_rows || empty_win) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (row_end) begin
               angle_in = lo_ff;
               if (row_ff == last_row_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in  = row_ff + ROW_BITS'(1);
                  base_in = base_ff + TABLE_ADDR_BITS'(ANGLES);
               end
            end else begin
               angle_in = angle_ff + ANGLE_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (!acc_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      last_row_ff <= last_row_in;
      angle_ff    <= angle_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> design/masked_sad_nearest_row_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_sad_nearest_row_search
// Nearest reference row by masked sum of absolute differences.
// ----------------------------------------------------------------------------
// The block keeps a table of reference distance vectors (8192 rows of 72
// angle sectors, unsigned Q8.8) in one single-port memory and a 72-entry
// query vector in a second one, with a present flag per query sector held
// in flip-flops that reset clears, so that query sectors never written count
// as absent. Table reads of entries never written return whatever the memory
// holds. Table and query writes are taken one per cycle while no search is
// running. A search request walks the first row_count rows and, in each
// row, every sector of the window from first_angle up to end_angle (capped
// at the last sector), one table read per cycle from the table memory's
// single port; absent sectors are still read but add nothing to the sum.
// After the last read the block lets the accumulator pipeline drain,
// moves the result into the response register and then becomes ready
// again for the next request. When the window is empty or no rows are
// examined, the walk and the drain are skipped and the result goes
// straight to the response register. A response register that is still
// full holds the block back until the response register empties.
// Each row sum saturates at 2^24-1, and the first row with a sum strictly
// below the running minimum (started at error_limit) is reported. While a
// search result waits on the response side, table and query writes are
// still accepted; a further search runs and holds its result until the
// response register is free. No clearing pass is needed after reset.
// Configuration should only be written while the block is idle.
// ----------------------------------------------------------------------------
module masked_sad_nearest_row_search import masr_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request channel
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // tdata from bit 0: row[12:0], angle[19:13], value[35:20], present[36], zero pad
   input  wire logic [39:0]              req_tdata,
   // tuser: kind[1:0]
   input  wire logic [KIND_BITS-1:0]     req_tuser,
   // Response channel
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // tdata from bit 0: best_row[12:0], best_error[36:13], found[37], zero pad
   output logic [39:0]                   rsp_tdata,
   // Configuration write port
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [ANGLE_BITS-1:0] first_angle_ff, first_angle_in;
   logic [ANGLE_BITS-1:0] end_angle_ff, end_angle_in;
   logic [COUNT_BITS-1:0] row_count_ff, row_count_in;
   logic [SUM_BITS-1:0]   error_limit_ff, error_limit_in;

   logic [ROW_BITS-1:0]        req_row;
   logic [ANGLE_BITS-1:0]      req_angle;
   logic [DIST_BITS-1:0]       req_value;
   logic                       req_present;
   logic                       table_we;
   logic [TABLE_ADDR_BITS-1:0] table_addr;
   logic [DIST_BITS-1:0]       table_rdata;
   logic                       query_we;
   logic [QUERY_ADDR_BITS-1:0] query_addr;
   logic [DIST_BITS-1:0]       query_rdata;
   logic                       acc_busy;
   masr_result_type            acc_result;
   masr_result_type            rsp_data;
   masr_ctl_type               ctl;

   // Unpack the request payload.
   assign req_row     = req_tdata[12:0];
   assign req_angle   = req_tdata[19:13];
   assign req_value   = req_tdata[35:20];
   assign req_present = req_tdata[36];

   // Configuration registers; indexes beyond the list cannot be encoded.
   always_comb begin
      first_angle_in = first_angle_ff;
      end_angle_in   = end_angle_ff;
      row_count_in   = row_count_ff;
      error_limit_in = error_limit_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_FIRST_ANGLE: first_angle_in = csr_wdata[ANGLE_BITS-1:0];
            CSR_END_ANGLE:   end_angle_in   = csr_wdata[ANGLE_BITS-1:0];
            CSR_ROW_COUNT:   row_count_in   = csr_wdata[COUNT_BITS-1:0];
            CSR_ERROR_LIMIT: error_limit_in = csr_wdata[SUM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_angle_ff <= '0;
         end_angle_ff   <= ANGLE_BITS'(ANGLES);
         row_count_ff   <= '0;
         error_limit_ff <= ERROR_LIMIT_RST;
      end else begin
         first_angle_ff <= first_angle_in;
         end_angle_ff   <= end_angle_in;
         row_count_ff   <= row_count_in;
         error_limit_ff <= error_limit_in;
      end
   end

   // Reference table: one row of ANGLES entries per map position.
   masr_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (table_we),
      .addr  (table_addr),
      .wdata (req_value),
      .rdata (table_rdata)
   );

   // Query distances; the present flags live in the sequencer.
   masr_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (ANGLES)
   ) u_query_ram (
      .clock (clock),
      .we    (query_we),
      .addr  (query_addr),
      .wdata (req_value),
      .rdata (query_rdata)
   );

   masr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_row     (req_row),
      .req_angle   (req_angle),
      .req_present (req_present),
      .first_angle (first_angle_ff),
      .end_angle   (end_angle_ff),
      .row_count   (row_count_ff),
      .acc_busy    (acc_busy),
      .acc_result  (acc_result),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_data    (rsp_data),
      .table_we    (table_we),
      .table_addr  (table_addr),
      .query_we    (query_we),
      .query_addr  (query_addr),
      .ctl         (ctl)
   );

   masr_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .table_rdata (table_rdata),
      .query_rdata (query_rdata),
      .error_limit (error_limit_ff),
      .busy        (acc_busy),
      .result      (acc_result)
   );

   assign rsp_tdata = {2'b00, rsp_data.found, rsp_data.best_error, rsp_data.best_row};

endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the masked SAD nearest-row search.
// ----------------------------------------------------------------------------
// Requests go in on the req_ stream and search results come out on the rsp_
// stream. The bench keeps its own copy of the reference map, the query
// vector and the search registers. When a request is accepted, it updates
// that copy and, for a search, works out the expected match. Each response
// is compared field by field with the oldest expected match. A short
// directed part covers reset defaults, the row-count extremes, ties, absent
// and out-of-range sectors and the window edges. Random traffic follows
// under three idling profiles.
// ----------------------------------------------------------------------------
module tb import masr_pkg::*; ();

   // Request kind that the block ignores.
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   // Generous watchdog.
   localparam int unsigned CYCLE_LIMIT = 5_000_000;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [39:0]              req_tdata  = '0;
   logic [KIND_BITS-1:0]     req_tuser  = KIND_TABLE_WRITE;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [39:0]              rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = CSR_FIRST_ANGLE;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   // Our copy of the block's state. A map cell that has never been written
   // has no entry in the associative array. That lets the bench make sure
   // a search never sums a cell that holds no defined value.
   bit [DIST_BITS-1:0] map_cells [int];
   bit [DIST_BITS-1:0] query_dist [ANGLES];
   bit                 query_on [ANGLES];

   int unsigned cfg_first_angle = 0;
   int unsigned cfg_end_angle   = ANGLES;
   int unsigned cfg_row_count   = 0;
   int unsigned cfg_error_limit = ERROR_LIMIT_RST;

   // Expected search results, oldest first.
   masr_result_type pending_matches [$];
   masr_result_type oldest_match;

   int unsigned mismatch_count     = 0;
   int unsigned cycle_count        = 0;
   int unsigned request_count      = 0;
   int unsigned sender_gap_pct     = 0;
   int unsigned receiver_stall_pct = 0;

   masked_sad_nearest_row_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   // Sum of absolute differences for one map row over the present query
   // sectors in the window, clamped at the largest 24-bit value.
   function automatic int unsigned row_distance(input int unsigned r);
      int unsigned sum;
      int unsigned stored;
      int unsigned q;
      int unsigned d;
      sum = 0;
      for (int unsigned a = cfg_first_angle; a < cfg_end_angle && a < ANGLES; a++) begin
         if (query_on[a]) begin
            stored = map_cells.exists(int'(r * ANGLES + a)) ? map_cells[int'(r * ANGLES + a)]
                                                            : 0;
            q      = query_dist[a];
            d      = (q >= stored) ? q - stored : stored - q;
            if (sum + d >= SUM_MAX)
               sum = SUM_MAX;
            else
               sum = sum + d;
         end
      end
      return sum;
   endfunction

   // The running minimum starts at the limit, and only a strictly smaller
   // sum replaces it. So on a tie the earlier row wins.
   function automatic masr_result_type nearest_row_search();
      masr_result_type best;
      int unsigned     rows_examined;
      int unsigned     sum;
      rows_examined   = (cfg_row_count < ROWS) ? cfg_row_count : ROWS;
      best.found      = 1'b0;
      best.best_error = SUM_BITS'(cfg_error_limit);
      best.best_row   = '0;
      for (int unsigned r = 0; r < rows_examined; r++) begin
         sum = row_distance(r);
         if (sum < best.best_error) begin
            best.best_error = SUM_BITS'(sum);
            best.best_row   = ROW_BITS'(r);
            best.found      = 1'b1;
         end
      end
      return best;
   endfunction

   // Distances lean towards the extremes and a few round values. This makes
   // equal row sums, and so ties, turn up now and then.
   function automatic int unsigned pick_distance();
      case ($urandom_range(7))
         0:       return 0;
         1:       return 16'hFFFF;
         2:       return 16'h0100 << $urandom_range(3);
         default: return $urandom_range(16'hFFFF);
      endcase
   endfunction

   // Present one request and hold it until the block takes it. Then update
   // our copy of the state. tvalid stays high after the handshake, and the
   // next request or wait_for_quiet decides whether it drops.
   task automatic send_request(input logic [KIND_BITS-1:0] kind, input int unsigned row,
                               input int unsigned angle, input int unsigned value,
                               input int unsigned present);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, 1'(present), 16'(value), 7'(angle), 13'(row)};
      do
         @(posedge clock);
      while (!req_tready);
      request_count++;

      case (kind)
         KIND_TABLE_WRITE:
            if (angle < ANGLES)
               map_cells[int'(row * ANGLES + angle)] = 16'(value);
         KIND_QUERY_WRITE:
            if (angle < ANGLES) begin
               query_dist[angle] = 16'(value);
               query_on[angle]   = 1'(present);
            end
         KIND_SEARCH:
            pending_matches.push_back(nearest_row_search());
         default: ;
      endcase
   endtask

   // Write every map cell that the next search would read and that has
   // never been written.
   task automatic write_missing_cells();
      int unsigned rows_examined;
      rows_examined = (cfg_row_count < ROWS) ? cfg_row_count : ROWS;
      for (int unsigned r = 0; r < rows_examined; r++)
         for (int unsigned a = cfg_first_angle; a < cfg_end_angle && a < ANGLES; a++)
            if (query_on[a] && !map_cells.exists(int'(r * ANGLES + a)))
               send_request(KIND_TABLE_WRITE, r, a, pick_distance(), $urandom_range(1));
   endtask

   task automatic send_search();
      write_missing_cells();
      send_request(KIND_SEARCH, $urandom_range(8191), $urandom_range(127),
                   $urandom_range(16'hFFFF), $urandom_range(1));
   endtask

   // Stop sending and let every outstanding search report. After that comes
   // a short pause so that the last writes have settled in the block.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Leaves csr_we high. apply_config lowers it after the last write.
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr, input int unsigned data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CSR_DATA_BITS'(data);
      @(posedge clock);
   endtask

   // All four registers are written every time, and only while the block
   // is idle.
   task automatic apply_config(input int unsigned first_angle, input int unsigned end_angle,
                               input int unsigned row_count, input int unsigned error_limit);
      wait_for_quiet();
      cfg_first_angle = first_angle & 7'h7F;
      cfg_end_angle   = end_angle & 7'h7F;
      cfg_row_count   = row_count & 14'h3FFF;
      cfg_error_limit = error_limit & 24'hFFFFFF;
      csr_write(CSR_FIRST_ANGLE, cfg_first_angle);
      csr_write(CSR_END_ANGLE, cfg_end_angle);
      csr_write(CSR_ROW_COUNT, cfg_row_count);
      csr_write(CSR_ERROR_LIMIT, cfg_error_limit);
      csr_we <= 1'b0;
   endtask

   // With no rows to examine, a search gives back the reset limit with
   // found low. The unused request kind must not produce a response.
   task automatic test_reset_defaults();
      send_search();
      send_request(KIND_UNUSED, 8191, 127, 16'hFFFF, 1);
      send_search();
   endtask

   // No query sector has been written yet, so every sector counts as
   // absent and every row sum is zero. The first pass examines every row
   // through a one-sector window. The second asks for more rows than the
   // map holds, through an empty window, with a limit of zero that nothing
   // can beat.
   task automatic test_row_count_extremes();
      apply_config(0, 1, ROWS, ERROR_LIMIT_RST);
      send_search();
      apply_config(ANGLES, 0, 16383, 0);
      send_search();
   endtask

   // Rows 1 and 2 are identical, so row 1 must win the tie. The limit is
   // then set equal to the best sum, which must not count as a match. The
   // last search uses a window that runs past the final sector.
   task automatic test_ties_and_window();
      apply_config(0, ANGLES, 3, SUM_MAX);
      send_request(KIND_QUERY_WRITE, 0, 0, 0, 1);
      send_request(KIND_QUERY_WRITE, 0, ANGLES - 1, 16'hFFFF, 1);
      send_request(KIND_QUERY_WRITE, 0, ANGLES, 16'h5555, 1);
      send_request(KIND_QUERY_WRITE, 8191, 127, 16'hFFFF, 1);
      send_request(KIND_QUERY_WRITE, 0, 5, 16'h1234, 0);
      send_request(KIND_TABLE_WRITE, 0, 0, 16'hFFFF, 0);
      send_request(KIND_TABLE_WRITE, 0, ANGLES - 1, 0, 0);
      send_request(KIND_TABLE_WRITE, 1, 0, 3, 0);
      send_request(KIND_TABLE_WRITE, 1, ANGLES - 1, 16'hFFFA, 0);
      send_request(KIND_TABLE_WRITE, 2, 0, 3, 1);
      send_request(KIND_TABLE_WRITE, 2, ANGLES - 1, 16'hFFFA, 1);
      send_request(KIND_TABLE_WRITE, 8191, ANGLES - 1, 16'hAAAA, 1);
      send_request(KIND_TABLE_WRITE, 8191, 127, 16'h5555, 0);
      send_search();
      apply_config(0, ANGLES, 3, 8);
      send_search();
      apply_config(ANGLES - 1, 127, 3, SUM_MAX);
      send_search();
   endtask

   // Mostly writes to a handful of low rows, so that searches over the
   // first few rows see changing data. Now and then a write goes to any
   // row, or to a sector past the end. The search registers change every
   // sixty requests. Every request sent counts towards the total, including
   // the map writes that a search needs first.
   task automatic run_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned request_total);
      int unsigned start_count;
      int unsigned next_setting;
      int unsigned pick;
      int unsigned first_angle;
      int unsigned end_angle;
      int unsigned row_count;
      int unsigned error_limit;
      int unsigned row;
      int unsigned angle;
      start_count  = request_count;
      next_setting = 0;
      while (request_count - start_count < request_total) begin
         if (request_count - start_count >= next_setting) begin
            case ($urandom_range(5))
               0:       first_angle = 0;
               1:       first_angle = ANGLES - 1;
               2:       first_angle = $urandom_range(127, ANGLES);
               default: first_angle = $urandom_range(ANGLES - 1);
            endcase
            case ($urandom_range(5))
               0:       end_angle = ANGLES;
               1:       end_angle = 127;
               2:       end_angle = $urandom_range(first_angle);
               3:       end_angle = (first_angle < 127) ? first_angle + 1 : 127;
               default: end_angle = $urandom_range(127, first_angle);
            endcase
            case ($urandom_range(5))
               0:       row_count = 0;
               1:       row_count = 1;
               2:       row_count = 8;
               default: row_count = $urandom_range(6, 1);
            endcase
            case ($urandom_range(6))
               0:       error_limit = ERROR_LIMIT_RST;
               1:       error_limit = SUM_MAX;
               2:       error_limit = 0;
               3:       error_limit = $urandom_range(400000);
               default: error_limit = $urandom_range(3000000);
            endcase
            apply_config(first_angle, end_angle, row_count, error_limit);
            // The idling profile starts only after the first setting, so
            // the directed part and each change of profile run cleanly.
            sender_gap_pct     = gap_pct;
            receiver_stall_pct = stall_pct;
            next_setting       = request_count - start_count + 60;
         end

         pick  = $urandom_range(99);
         row   = ($urandom_range(4) == 0) ? $urandom_range(8191) : $urandom_range(9);
         angle = ($urandom_range(9) == 0) ? $urandom_range(127, ANGLES)
                                          : $urandom_range(ANGLES - 1);
         if (pick < 52) begin
            send_request(KIND_TABLE_WRITE, row, angle, pick_distance(), $urandom_range(1));
         end else if (pick < 80) begin
            send_request(KIND_QUERY_WRITE, row, angle, pick_distance(),
                         ($urandom_range(4) != 0));
         end else if (pick < 95) begin
            send_search();
         end else begin
            send_request(KIND_UNUSED, row, angle, pick_distance(), $urandom_range(1));
         end
      end
   endtask

   // Response side: a response is taken at an edge where both tvalid and
   // tready are high. The values sampled here are the ones from before the
   // edge, and tready for the next cycle is chosen after the check.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("response %h with no search outstanding", rsp_tdata));
         end else begin
            oldest_match = pending_matches.pop_front();
            if (rsp_tdata[12:0] !== oldest_match.best_row)
               report_mismatch($sformatf("best_row %0d, expected %0d",
                                         rsp_tdata[12:0], oldest_match.best_row));
            if (rsp_tdata[36:13] !== oldest_match.best_error)
               report_mismatch($sformatf("best_error %0d, expected %0d",
                                         rsp_tdata[36:13], oldest_match.best_error));
            if (rsp_tdata[37] !== oldest_match.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_tdata[37], oldest_match.found));
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_row_count_extremes();
      test_ties_and_window();
      run_random_traffic(33, 78, 430);
      run_random_traffic(78, 33, 430);
      run_random_traffic(0, 0, 430);

      wait_for_quiet();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

>>> sim.f
design/masr_pkg.sv
design/masr_ram.sv
design/masr_acc.sv
design/masr_seq.sv
design/masked_sad_nearest_row_search.sv
test/tb.sv
